FILE: rtl/core/jeu_pkg.sv
package jeu_pkg;

  localparam int unsigned WinDepth = 12;
  localparam int unsigned CntW     = 4;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) r = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) r = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) r = 4'(c - 8'h37);
    return r;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/jeu_queue.sv
module jeu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  jeu_pkg::item_t wr_item_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output jeu_pkg::item_t rd_item_o
);
  import jeu_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != (QPtrW+1)'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrW+1)'(QDepth)) else $error("queue overfill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> rd_valid_o) else $error("queue lost item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr && cnt_q == (QPtrW+1)'(1)) |=> !rd_valid_o) else $error("queue count");
endmodule

FILE: rtl/core/jeu_back.sv
module jeu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jeu_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jeu_pkg::item_t out_item_o
);
  import jeu_pkg::*;

  localparam logic [1:0] StFill = 2'd0;
  localparam logic [1:0] StEmit = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]      st_q, st_d;
  logic [7:0]      win_q [WinDepth];
  logic [CntW-1:0] cnt_q;
  logic            fin_q;
  logic [7:0]      ob_q [4];
  logic [2:0]      on_q, oi_q;
  logic [3:0]      drop_q;

  // decision on current window
  logic [15:0] q1, q2;
  logic        pair, act, can;
  logic [7:0]  nb [4];
  logic [2:0]  nn;
  logic [3:0]  nd;
  logic [20:0] cp;
  logic [9:0]  hi, lo;
  logic [15:0] t1, t2;

  always_comb begin
    q1 = {hex_digit(win_q[2]), hex_digit(win_q[3]), hex_digit(win_q[4]), hex_digit(win_q[5])};
    q2 = {hex_digit(win_q[8]), hex_digit(win_q[9]), hex_digit(win_q[10]), hex_digit(win_q[11])};
    pair = (cnt_q == CntW'(WinDepth)) &&
      (win_q[2] == 8'h64 || win_q[2] == 8'h44) &&
      (win_q[3] == 8'h38 || win_q[3] == 8'h39 || win_q[3] == 8'h41 || win_q[3] == 8'h61 ||
       win_q[3] == 8'h42 || win_q[3] == 8'h62) &&
      win_q[6] == ChBslash && win_q[7] == ChU &&
      (win_q[8] == 8'h64 || win_q[8] == 8'h44) &&
      ((win_q[9] >= 8'h43 && win_q[9] <= 8'h46) || (win_q[9] >= 8'h63 && win_q[9] <= 8'h66));
    t1 = q1 - 16'hD800;
    t2 = q2 - 16'hDC00;
    hi = t1[9:0];
    lo = t2[9:0];
    cp = 21'h10000 + {1'b0, hi, lo};
    act = 1'b0; can = 1'b0;
    nb[0] = win_q[0]; nb[1] = '0; nb[2] = '0; nb[3] = '0;
    nn = 3'd1; nd = 4'd1;
    if (cnt_q != '0) begin
      if (win_q[0] != ChBslash) begin
        act = 1'b1;
      end else if (cnt_q < CntW'(2)) begin
        act = fin_q;
      end else if (win_q[1] != ChU) begin
        act = 1'b1; nb[0] = escape_map(win_q[1]); nd = 4'd2;
      end else if (cnt_q < CntW'(6)) begin
        act = fin_q; nb[0] = ChU; nd = 4'd2;
      end else if (cnt_q < CntW'(WinDepth) && !fin_q) begin
        act = 1'b0;
      end else if (pair) begin
        act = 1'b1; nn = 3'd4; nd = 4'd12;
        nb[0] = 8'hF0 + 8'(cp[20:18]);
        nb[1] = 8'h80 + 8'(cp[17:12]);
        nb[2] = 8'h80 + 8'(cp[11:6]);
        nb[3] = 8'h80 + 8'(cp[5:0]);
      end else begin
        act = 1'b1; nd = 4'd6;
        if (q1 <= 16'h7F) begin
          nb[0] = q1[7:0];
        end else if (q1 <= 16'h7FF) begin
          nn = 3'd2;
          nb[0] = 8'hC0 + 8'(q1[10:6]);
          nb[1] = 8'h80 + 8'(q1[5:0]);
        end else begin
          nn = 3'd3;
          nb[0] = 8'hE0 + 8'(q1[15:12]);
          nb[1] = 8'h80 + 8'(q1[11:6]);
          nb[2] = 8'h80 + 8'(q1[5:0]);
        end
      end
    end
    can = act;
  end

  assign in_ready_o  = (st_q == StFill) && !can && !fin_q;
  assign out_valid_o = (st_q == StEmit);
  assign out_item_o.data = ob_q[oi_q[1:0]];
  assign out_item_o.last = fin_q && (oi_q == on_q - 3'd1) &&
                           (cnt_q == CntW'(drop_q) || cnt_q < CntW'(drop_q));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StFill:  if (can) st_d = StEmit;
      StEmit:  if (out_ready_i && oi_q == on_q - 3'd1) st_d = StDrain;
      StDrain: st_d = StFill;
      default: st_d = StFill;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StFill && can) begin
      for (int i = 0; i < 4; i++) ob_q[i] <= nb[i];
      on_q   <= nn;
      drop_q <= nd;
    end
    if (st_q == StDrain) begin
      for (int i = 0; i < WinDepth; i++)
        if (i + int'(drop_q) < WinDepth) win_q[i] <= win_q[i + int'(drop_q)];
    end else if (in_valid_i && in_ready_o && cnt_q < CntW'(WinDepth)) begin
      win_q[cnt_q] <= in_item_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StFill;
      cnt_q <= '0;
      fin_q <= 1'b0;
      oi_q  <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StFill && can) oi_q <= '0;
      else if (st_q == StEmit && out_ready_i) oi_q <= oi_q + 3'd1;
      if (st_q == StDrain) begin
        if (cnt_q <= CntW'(drop_q)) begin
          cnt_q <= '0;
          fin_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - CntW'(drop_q);
        end
      end else if (in_valid_i && in_ready_o) begin
        if (cnt_q < CntW'(WinDepth)) cnt_q <= cnt_q + 1'b1;
        fin_q <= in_item_i.last;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(WinDepth)) else $error("window overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StEmit) |-> (on_q != 3'd0 && oi_q < on_q)) else $error("emit index");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_item_o.last) |=> (st_q == StDrain))
    else $error("last not at end");
endmodule

FILE: rtl/core/json_escape_to_utf8_unescaper_top.sv
// channel | direction | handshake         | tdata              | tuser
// s_axis  | in        | s_axis_tvalid/rdy | [7:0] in_byte      | -  (tlast = in_last)
// m_axis  | out       | m_axis_tvalid/rdy | [7:0] out_byte     | -  (tlast = out_last)
// Input bytes enter a 4-entry queue at one per cycle while it has room.
// The back end handles one escape at a time: it decides in StFill, sends the
// output bytes (1 to 4) in StEmit and shifts the 12-byte window in StDrain;
// an escape waits for up to 12 bytes or the frame end. Reset (rst_ni, async)
// empties queue and window. Either side may stall without loss.
module json_escape_to_utf8_unescaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic       m_axis_tlast
);
  import jeu_pkg::*;

  item_t in_item, q_item, out_item;
  logic  q_valid, q_ready;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  jeu_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (s_axis_tvalid), .wr_ready_o (s_axis_tready), .wr_item_i (in_item),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_item_o (q_item)
  );

  jeu_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid), .in_ready_o (q_ready), .in_item_i (q_item),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready), .out_item_o (out_item)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tlast = out_item.last;
endmodule

FILE: tb/sv/jeu_stream_checker.sv
`timescale 1ns / 100ps

module jeu_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  localparam int unsigned HoldDepth = 12;
  localparam logic [7:0] Bslash = 8'h5C;
  localparam logic [7:0] LetterU = 8'h75;

  logic [7:0]  held [HoldDepth];
  int unsigned held_cnt;
  out_byte_t   expected_q [$];
  out_byte_t   step_q [$];

  function automatic logic [15:0] nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 16'(c - "0");
    if (c >= "a" && c <= "f") return 16'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 16'(c - "A" + 10);
    return 16'd0;
  endfunction

  function automatic logic [15:0] quad_at(input int unsigned p);
    return (nibble(held[p]) << 12) | (nibble(held[p+1]) << 8) |
           (nibble(held[p+2]) << 4) | nibble(held[p+3]);
  endfunction

  function automatic bit is_pair();
    logic [7:0] a, b;
    a = held[3];
    b = held[9];
    if (held[2] != "d" && held[2] != "D") return 0;
    if (!(a inside {"8", "9", "A", "a", "B", "b"})) return 0;
    if (held[6] != Bslash || held[7] != LetterU) return 0;
    if (held[8] != "d" && held[8] != "D") return 0;
    return b inside {"C", "c", "D", "d", "E", "e", "F", "f"};
  endfunction

  function automatic logic [7:0] ctrl_of(input logic [7:0] c);
    case (c)
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      default: return c;
    endcase
  endfunction

  task automatic emit(input logic [31:0] v);
    out_byte_t e;
    if (step_q.size() < HoldDepth) begin
      e.data = v[7:0];
      e.last = 1'b0;
      step_q.push_back(e);
    end
  endtask

  task automatic shift_out(input int unsigned n);
    if (n >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int unsigned i = 0; i < held_cnt - n; i++) held[i] = held[i+n];
      held_cnt -= n;
    end
  endtask

  // advance the decoder by one input byte, collecting the produced bytes
  task automatic unescape_byte(input logic [7:0] b, input logic fin);
    logic [31:0] hi, lo, cp;
    step_q.delete();
    if (held_cnt < HoldDepth) begin
      held[held_cnt] = b;
      held_cnt++;
    end
    while (held_cnt > 0) begin
      if (held[0] != Bslash) begin
        emit(32'(held[0]));
        shift_out(1);
      end else if (held_cnt < 2) begin
        if (!fin) break;
        emit(32'(Bslash));
        shift_out(1);
      end else if (held[1] != LetterU) begin
        emit(32'(ctrl_of(held[1])));
        shift_out(2);
      end else if (held_cnt < 6) begin
        if (!fin) break;
        emit(32'(LetterU));
        shift_out(2);
      end else if (held_cnt < HoldDepth && !fin) begin
        break;
      end else if (held_cnt >= HoldDepth && is_pair()) begin
        hi = (32'(quad_at(2)) - 32'hD800) & 32'h3FF;
        lo = (32'(quad_at(8)) - 32'hDC00) & 32'h3FF;
        cp = 32'h10000 + ((hi << 10) | lo);
        emit(32'hF0 + (cp >> 18));
        emit(32'h80 + ((cp >> 12) & 32'h3F));
        emit(32'h80 + ((cp >> 6) & 32'h3F));
        emit(32'h80 + (cp & 32'h3F));
        shift_out(12);
      end else begin
        cp = 32'(quad_at(2));
        if (cp <= 32'h7F) begin
          emit(cp);
        end else if (cp <= 32'h7FF) begin
          emit(32'hC0 + (cp >> 6));
          emit(32'h80 + (cp & 32'h3F));
        end else begin
          emit(32'hE0 + (cp >> 12));
          emit(32'h80 + ((cp >> 6) & 32'h3F));
          emit(32'h80 + (cp & 32'h3F));
        end
        shift_out(6);
      end
    end
    if (fin) begin
      held_cnt = 0;
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    end
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endtask

  task automatic report(input string what, input logic [7:0] got_d, input logic got_l,
                        input logic [7:0] exp_d, input logic exp_l);
    $display("%0t: %s: got %02h/%0b, want %02h/%0b", $realtime, what, got_d, got_l,
             exp_d, exp_l);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_byte_t e;
    if (!rst_ni) begin
      held_cnt = 0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) unescape_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer", m_axis_tdata, m_axis_tlast, 8'h00, 1'b0);
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.data || m_axis_tlast !== e.last)
            report("wrong output", m_axis_tdata, m_axis_tlast, e.data, e.last);
        end
      end
    end
    pending_o = expected_q.size();
  end

  final begin
  end

endmodule

FILE: tb/sv/json_escape_to_utf8_unescaper_top_tb.sv
`timescale 1ns / 100ps

module json_escape_to_utf8_unescaper_top_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomItems = 290;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  int unsigned sent = 0;

  always #10 clk_i = ~clk_i;

  json_escape_to_utf8_unescaper_top dut (.*);

  jeu_stream_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall bursts until the calm tail
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("json_escape_to_utf8_unescaper_top: mismatch");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_string(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input bit upper, input int unsigned v);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  task automatic send_uesc(input logic [15:0] v, input logic fin);
    send_byte("\\", 1'b0);
    send_byte("u", 1'b0);
    for (int i = 3; i >= 0; i--)
      send_byte(hex_char(1'($urandom_range(0, 1)), 32'(v[i*4 +: 4])), fin && i == 0);
  endtask

  // one frame: well-formed escapes with random content, plus noise
  task automatic send_random_frame();
    int unsigned parts, kind;
    logic [7:0] c;
    string esc_set;
    esc_set = "bfnrt\"/\\";
    parts = $urandom_range(1, 5);
    for (int unsigned p = 0; p < parts; p++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          c = 8'($urandom_range(0, 255));
          send_byte(c, p == parts - 1);
        end
        2: begin
          send_byte("\\", 1'b0);
          c = esc_set[$urandom_range(0, 7)];
          send_byte(c, p == parts - 1);
        end
        3: send_uesc(16'($urandom_range(0, 16'h7F)), p == parts - 1);
        4: send_uesc(16'($urandom_range(16'h80, 16'h7FF)), p == parts - 1);
        5: send_uesc(16'($urandom_range(0, 16'hFFFF)), p == parts - 1);
        6, 7: begin
          send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
          send_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)), p == parts - 1);
        end
        8: begin
          send_byte("\\", 1'b0);
          send_byte("u", 1'b0);
          repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
          send_byte(8'($urandom_range(0, 255)), p == parts - 1);
        end
        default: begin
          send_byte("\\", p == parts - 1);
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_string("a\\n\\t\\b\\f\\r\\q", 1'b1);
    send_uesc(16'h0041, 1'b0);
    send_uesc(16'h07FF, 1'b0);
    send_uesc(16'hFFFF, 1'b1);
    send_string("\\ud83d\\ude00", 1'b1);
    send_string("\\uDBFF\\uDFFFx\\uzz9g", 1'b1);
    send_string("\\uD800", 1'b1);
    send_string("\\u12", 1'b1);
    send_string("\\", 1'b1);
    // hold off until every expected result has come out
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    while (sent < RandomItems) begin
      if (sent > RandomItems * 4 / 5) calm = 1'b1;
      send_random_frame();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("json_escape_to_utf8_unescaper_top: match");
    else $display("json_escape_to_utf8_unescaper_top: mismatch");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/jeu_pkg.sv
rtl/core/jeu_queue.sv
rtl/core/jeu_back.sv
rtl/core/json_escape_to_utf8_unescaper_top.sv
tb/sv/jeu_stream_checker.sv
tb/sv/json_escape_to_utf8_unescaper_top_tb.sv
